@@ design/tag_text_to_utf8_core_defines.svh @@
// ----------------------------------------------------------------------------
// tag_text_to_utf8_core_defines
// assertion macros shared by the checker of the text transcoder
// ----------------------------------------------------------------------------
`ifndef TAG_TEXT_TO_UTF8_CORE_DEFINES_SVH
`define TAG_TEXT_TO_UTF8_CORE_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define TTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form on top of the plain one
`define TTU_ASSERT_IMP(label, ante, cons, msg) \
  `TTU_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ design/ttu_pkg.sv @@
// ----------------------------------------------------------------------------
// ttu_pkg
// types and constants shared by the text-to-utf8 transcoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

  localparam int unsigned FifoDepthDef = 4;

  // sampled encoding codes
  localparam logic [7:0] EncLatin1  = 8'd0;
  localparam logic [7:0] EncUtf16   = 8'd1;
  localparam logic [7:0] EncUtf16be = 8'd2;
  localparam logic [7:0] EncUtf8    = 8'd3;

  // internal mode codes
  localparam logic [2:0] ModeLatin1  = 3'd0;
  localparam logic [2:0] ModeUtf16   = 3'd1;
  localparam logic [2:0] ModeUtf16be = 3'd2;
  localparam logic [2:0] ModeUtf8    = 3'd3;
  localparam logic [2:0] ModeUnknown = 3'd4;

  localparam logic [7:0] BomHi = 8'hFF;
  localparam logic [7:0] BomLo = 8'hFE;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_UNIT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] value;
    logic        last;
  } ttu_cmd_t;

endpackage

`default_nettype wire

@@ design/ttu_front.sv @@
// ----------------------------------------------------------------------------
// ttu_front
// accepts input beats, tracks field state and emits at most one command per beat
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_front import ttu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] text_encoding_i,
  input  wire logic     field_first_i,
  input  wire logic     field_final_i,
  output logic          push_o,
  output ttu_cmd_t      cmd_o
);

  logic [2:0] mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       half_q, half_d;
  logic       pend_q, pend_d;
  logic       be_q, be_d;
  logic       stop_q, stop_d;
  logic       emit;

  always_comb begin
    logic [2:0]  m;
    logic        is_mark;
    logic [15:0] unit;
    mode_d  = mode_q;
    held_d  = held_q;
    half_d  = half_q;
    pend_d  = pend_q;
    be_d    = be_q;
    stop_d  = stop_q;
    emit    = 1'b0;
    cmd_o   = '{kind: CMD_END, value: 16'd0, last: 1'b1};
    is_mark = 1'b0;
    unit    = 16'd0;
    if (field_first_i) begin
      stop_d = 1'b0;
      mode_d = (text_encoding_i <= EncUtf8) ? text_encoding_i[2:0] : ModeUnknown;
      held_d = 8'd0;
      half_d = 1'b0;
      pend_d = (text_encoding_i == EncUtf16);
      be_d   = (text_encoding_i == EncUtf16be);
    end
    m = mode_d;
    if (!stop_d) begin
      case (m)
        ModeLatin1, ModeUtf8: begin
          emit = 1'b1;
          if (data_byte_i == 8'd0) begin
            stop_d = 1'b1;
          end else begin
            cmd_o  = '{kind: CMD_BYTE, value: {8'd0, data_byte_i}, last: field_final_i};
            stop_d = field_final_i;
          end
        end
        ModeUtf16, ModeUtf16be: begin
          if (!half_d) begin
            held_d = data_byte_i;
            half_d = 1'b1;
            if (field_final_i) begin
              emit   = 1'b1;
              stop_d = 1'b1;
            end
          end else begin
            half_d = 1'b0;
            if (pend_d) begin
              pend_d = 1'b0;
              if (held_d == BomHi && data_byte_i == BomLo) begin
                be_d    = 1'b0;
                is_mark = 1'b1;
              end else if (held_d == BomLo && data_byte_i == BomHi) begin
                be_d    = 1'b1;
                is_mark = 1'b1;
              end
            end
            unit = be_d ? {held_d, data_byte_i} : {data_byte_i, held_d};
            if (is_mark) begin
              // a skipped mark only ends the text when it is the last unit
              if (field_final_i) begin
                emit   = 1'b1;
                stop_d = 1'b1;
              end
            end else if (unit == 16'd0) begin
              emit   = 1'b1;
              stop_d = 1'b1;
            end else begin
              emit   = 1'b1;
              cmd_o  = '{kind: CMD_UNIT, value: unit, last: field_final_i};
              stop_d = field_final_i;
            end
          end
        end
        default: begin
          emit   = 1'b1;
          stop_d = 1'b1;
        end
      endcase
    end
  end

  assign push_o = accept_i & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLatin1;
      held_q <= 8'd0;
      half_q <= 1'b0;
      pend_q <= 1'b0;
      be_q   <= 1'b0;
      stop_q <= 1'b1;
    end else if (accept_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      half_q <= half_d;
      pend_q <= pend_d;
      be_q   <= be_d;
      stop_q <= stop_d;
    end
  end

endmodule

`default_nettype wire

@@ design/ttu_fifo.sv @@
// ----------------------------------------------------------------------------
// ttu_fifo
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_fifo import ttu_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  ttu_cmd_t  data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output ttu_cmd_t  data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  ttu_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntMax);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrMax) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrMax) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/ttu_back.sv @@
// ----------------------------------------------------------------------------
// ttu_back
// expands queued commands into utf-8 output beats, one byte per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_back import ttu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  ttu_cmd_t        cmd_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  output logic            m_axis_tuser,
  output logic            m_axis_tlast
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] n_bytes;
  logic [7:0] byte_d;
  logic       last_byte, load;
  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       present_q, end_q;

  always_comb begin
    n_bytes = 2'd1;
    byte_d  = 8'd0;
    case (cmd_i.kind)
      CMD_BYTE: begin
        byte_d = cmd_i.value[7:0];
      end
      CMD_UNIT: begin
        if (cmd_i.value < 16'h0080) begin
          byte_d = cmd_i.value[7:0];
        end else if (cmd_i.value < 16'h0800) begin
          n_bytes = 2'd2;
          byte_d  = (idx_q == 2'd0) ? {3'b110, cmd_i.value[10:6]}
                                    : {2'b10, cmd_i.value[5:0]};
        end else begin
          n_bytes = 2'd3;
          case (idx_q)
            2'd0:    byte_d = {4'b1110, cmd_i.value[15:12]};
            2'd1:    byte_d = {2'b10, cmd_i.value[11:6]};
            default: byte_d = {2'b10, cmd_i.value[5:0]};
          endcase
        end
      end
      default: begin
        byte_d = 8'd0;
      end
    endcase
  end

  assign last_byte = (idx_q == n_bytes - 2'd1);
  assign load      = cmd_valid_i & (~valid_q | m_axis_tready);
  assign pop_o     = load & last_byte;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_byte ? 2'd0 : idx_q + 2'd1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q    <= byte_d;
      present_q <= (cmd_i.kind != CMD_END);
      end_q     <= last_byte & cmd_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = present_q;
  assign m_axis_tlast  = end_q;

endmodule

`default_nettype wire

@@ design/tag_text_to_utf8_core.sv @@
// Passes Latin-1 and UTF-8 bytes through and turns UTF-16 into UTF-8. Input
// beats are taken one per cycle while the command queue has room; the front
// end decides on each beat in that same cycle, and the back end sends out one
// UTF-8 byte per cycle from its output register while the output is not
// stalled. A UTF-16 code unit takes two input beats and is sent as one to
// three output bytes. The command for an input beat is written into the queue
// first, and its first output byte then goes through the back end's output
// register before it is valid.
// ----------------------------------------------------------------------------
// tag_text_to_utf8_core
// streaming tag text transcoder: latin1 / utf-8 pass-through, utf-16 to utf-8
// ----------------------------------------------------------------------------
`default_nettype none

module tag_text_to_utf8_core import ttu_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  wire logic [8:0] s_axis_tuser,  // [7:0] text_encoding, [8] field_first
  input  wire logic       s_axis_tlast,  // field_final
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
  output logic            m_axis_tuser,  // [0] byte_present
  output logic            m_axis_tlast   // text_end
);

  logic     accept, push, full, pop, cmd_valid;
  ttu_cmd_t cmd_in, cmd_out;

  assign s_axis_tready = ~full;
  assign accept        = s_axis_tvalid & ~full;

  ttu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (s_axis_tdata),
    .text_encoding_i (s_axis_tuser[7:0]),
    .field_first_i   (s_axis_tuser[8]),
    .field_final_i   (s_axis_tlast),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  ttu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  ttu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ design/ttu_checker.sv @@
// ----------------------------------------------------------------------------
// ttu_checker
// port-level checks for the text transcoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "tag_text_to_utf8_core_defines.svh"

module ttu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic [8:0] s_axis_tuser,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser,
  input wire logic       m_axis_tlast
);

  `TTU_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "output beat dropped while stalled")
  `TTU_ASSERT_IMP(a_out_stable, m_axis_tvalid && !m_axis_tready, ##1 ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "output beat changed while stalled")
  `TTU_ASSERT_IMP(a_marker_ends, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0), "bare marker not an empty end beat")
  `TTU_ASSERT_IMP(a_no_zero_byte, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 8'd0, "zero byte sent as text")

endmodule

bind tag_text_to_utf8_core ttu_checker u_ttu_checker (.*);

`default_nettype wire
